// ----- src/mkd_pkg.sv -----
package mkd_pkg;

    localparam int KEY_W    = 32;
    localparam int NIB_W    = 4;
    localparam int PHASE_W  = 3;
    localparam int ROW_W    = 2;
    localparam int CNT_N    = 5;
    localparam int CNT_IDX_W = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // counter entry 4 belongs to the selection switches
    localparam logic [CNT_IDX_W-1:0] SW_ENTRY = 3'd4;

    typedef logic [NIB_W-1:0] t_nib;

    typedef enum logic [1:0] {
        ACT_TICK         = 2'd0,
        ACT_READ         = 2'd1,
        ACT_TAKE_PRESS   = 2'd2,
        ACT_TAKE_RELEASE = 2'd3
    } t_action;

    // lowest bit of the key nibble that a counter entry covers
    function automatic logic [4:0] nib_base(input logic [CNT_IDX_W-1:0] idx);
        logic [4:0] base;
        case (idx)
            3'd0:    base = 5'd0;
            3'd1:    base = 5'd8;
            3'd2:    base = 5'd16;
            3'd3:    base = 5'd24;
            3'd4:    base = 5'd4;
            default: base = 5'd0;
        endcase
        return base;
    endfunction

endpackage

// ----- src/mkd_vcnt.sv -----
module mkd_vcnt (
    input  mkd_pkg::t_nib i_stable,
    input  mkd_pkg::t_nib i_sample,
    input  mkd_pkg::t_nib i_cnt_lo,
    input  mkd_pkg::t_nib i_cnt_hi,
    output mkd_pkg::t_nib o_cnt_lo,
    output mkd_pkg::t_nib o_cnt_hi,
    output mkd_pkg::t_nib o_flip
);
    import mkd_pkg::*;

    t_nib diff;

    // two-bit vertical counter per key: counts down while the sample differs,
    // reloads when it agrees; flip when both bits reach one again
    assign diff     = i_stable ^ i_sample;
    assign o_cnt_lo = ~(i_cnt_lo & diff);
    assign o_cnt_hi = o_cnt_lo ^ (i_cnt_hi & diff);
    assign o_flip   = diff & o_cnt_lo & o_cnt_hi;

endmodule

// ----- src/matrix_keypad_debounce_scanner.sv -----
// Debounced scanner for a 4x4 key matrix plus four selection switches. Each
// input item is a scan tick (tuser 0) or a query (1 read state, 2 take and
// clear presses, 3 take and clear releases) masked by the 32-bit mask. A tick
// steps an eight-phase scan: even phases drive row phase/2 low, odd phases
// sample that row's active-low columns, phase 0 also samples the switches.
// A key's stable state flips after four consecutive differing samples and
// sets its sticky press or release latch. Key bits: 3:0 row 0, 7:4 switches,
// 11:8 row 1, 19:16 row 2, 27:24 row 3. Every item yields one result item
// carrying the answer (zero for ticks) and the row driven when the item came
// in. One item per clock unless the output stalls: all state updates in the
// accept cycle; one output register holds a result while the next is taken.
module matrix_keypad_debounce_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column_pins[3:0], switch_pins[7:4], mask[39:8]
    input  logic [mkd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // value[31:0], row_drive[33:32], zero[39:34]
    output logic [mkd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mkd_pkg::*;

    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [KEY_W-1:0]     r_stable, n_stable;
    logic [KEY_W-1:0]     r_press, n_press;
    logic [KEY_W-1:0]     r_release, n_release;
    t_nib                 r_cnt_lo [CNT_N];
    t_nib                 r_cnt_hi [CNT_N];
    logic                 r_out_valid;
    logic [KEY_W-1:0]     r_out_value, n_out_value;
    logic [ROW_W-1:0]     r_out_row;

    logic                 accept;
    t_action              action;
    t_nib                 cols;
    t_nib                 sw;
    logic [KEY_W-1:0]     mask;
    logic [ROW_W-1:0]     row;
    logic [CNT_IDX_W-1:0] idx;
    logic [4:0]           base;
    logic                 do_sample;
    t_nib                 stab_nib;
    t_nib                 sample;
    t_nib                 cnt_lo_nx;
    t_nib                 cnt_hi_nx;
    t_nib                 flip;
    logic [KEY_W-1:0]     flip_w;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign action = t_action'(s_axis_tuser);
    assign cols   = s_axis_tdata[3:0];
    assign sw     = s_axis_tdata[7:4];
    assign mask   = s_axis_tdata[39:8];

    assign row       = r_phase[PHASE_W-1:1];
    assign idx       = r_phase[0] ? {1'b0, row} : SW_ENTRY;
    assign base      = nib_base(idx);
    assign do_sample = r_phase[0] || (r_phase == '0);
    assign stab_nib  = t_nib'(r_stable >> base);
    assign sample    = r_phase[0] ? ~cols : sw;

    mkd_vcnt u_vcnt (
        .i_stable (stab_nib),
        .i_sample (sample),
        .i_cnt_lo (r_cnt_lo[idx]),
        .i_cnt_hi (r_cnt_hi[idx]),
        .o_cnt_lo (cnt_lo_nx),
        .o_cnt_hi (cnt_hi_nx),
        .o_flip   (flip)
    );

    assign flip_w = KEY_W'(flip) << base;

    always_comb begin
        n_phase     = r_phase;
        n_stable    = r_stable;
        n_press     = r_press;
        n_release   = r_release;
        n_out_value = '0;
        case (action)
            ACT_TICK: begin
                if (do_sample) begin
                    n_stable  = r_stable ^ flip_w;
                    n_press   = r_press | (n_stable & flip_w);
                    n_release = r_release | (~n_stable & flip_w);
                end
                n_phase = r_phase + 1'b1;
            end
            ACT_READ: begin
                n_out_value = mask & r_stable;
            end
            ACT_TAKE_PRESS: begin
                n_out_value = mask & r_press;
                n_press     = r_press ^ n_out_value;
            end
            ACT_TAKE_RELEASE: begin
                n_out_value = mask & r_release;
                n_release   = r_release ^ n_out_value;
            end
            default: begin
                n_out_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_stable  <= '0;
            r_press   <= '0;
            r_release <= '0;
            for (int k = 0; k < CNT_N; k++) begin
                r_cnt_lo[k] <= '1;
                r_cnt_hi[k] <= '1;
            end
        end else if (accept) begin
            r_phase   <= n_phase;
            r_stable  <= n_stable;
            r_press   <= n_press;
            r_release <= n_release;
            if (action == ACT_TICK && do_sample) begin
                r_cnt_lo[idx] <= cnt_lo_nx;
                r_cnt_hi[idx] <= cnt_hi_nx;
            end
        end
    end

    // hold the result until taken; a new item may load it in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value <= n_out_value;
            r_out_row   <= row;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - KEY_W - ROW_W){1'b0}}, r_out_row, r_out_value};

endmodule
